// ----- hdl/pfx_pkg.sv -----
// pfx_pkg: constants, types and tables shared by the pixel effect unit
// no dependencies; compiled first
package pfx_pkg;

	// coordinate range and ripple period
	localparam int MaxDim = 4096;
	localparam logic [11:0] CoordMask = 12'(MaxDim - 1);
	localparam int RipplePeriod = 50;
	localparam int RippleIdxW = $clog2(RipplePeriod);
	localparam int RippleShift = 24;
	localparam int RippleRecipW = 24;
	localparam logic [RippleRecipW-1:0] RippleRecip =
		RippleRecipW'((2 ** RippleShift + RipplePeriod - 1) / RipplePeriod);
	localparam int RippleProdW = 12 + RippleRecipW;

	// configuration port
	localparam int CfgIdxW = 2;
	localparam int CfgDataW = 13;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_MODE   = 2'd0,
		CFG_WIDTH  = 2'd1,
		CFG_HEIGHT = 2'd2
	} cfg_reg_t;

	typedef enum logic [3:0] {
		FX_NONE    = 4'd0,
		FX_GRAY    = 4'd1,
		FX_INVERT  = 4'd2,
		FX_MIRROR  = 4'd3,
		FX_ZERO_R  = 4'd4,
		FX_ZERO_G  = 4'd5,
		FX_ZERO_B  = 4'd6,
		FX_SEPIA   = 4'd7,
		FX_WAVE    = 4'd8,
		FX_FISHEYE = 4'd9
	} effect_t;

	// sepia matrix, rows are output channels, Q0.10
	localparam logic [9:0] SepiaCoef [3][3] = '{
		'{10'd402, 10'd787, 10'd194},
		'{10'd357, 10'd702, 10'd172},
		'{10'd279, 10'd547, 10'd134}
	};
	// floor(s / 3) as (s * 683) >> 11, exact for s up to 765
	localparam logic [9:0] GrayRecip = 10'd683;

	// fisheye arithmetic
	localparam int SqrtInW = 43;
	localparam int RootW = 22;
	localparam int SqrtSteps = 22;
	localparam int M8W = 17;
	localparam logic [M8W-1:0] M8Cap = 17'd102400;
	localparam int DivNumW = M8W + 16;
	localparam int DivSteps = 25;
	localparam int QW = 27;
	localparam int SideLen = SqrtSteps + DivSteps + 3;

	localparam int WaveLen = 50;
	localparam logic signed [3:0] WaveTable [WaveLen] = '{
		4'sd0, 4'sd0, 4'sd1, 4'sd1, 4'sd2, 4'sd2, 4'sd3, 4'sd3, 4'sd4, 4'sd4,
		4'sd4, 4'sd4, 4'sd4, 4'sd4, 4'sd4, 4'sd4, 4'sd4, 4'sd4, 4'sd3, 4'sd3,
		4'sd2, 4'sd2, 4'sd1, 4'sd0, 4'sd0, 4'sd0, 4'sd0, -4'sd1, -4'sd2, -4'sd2,
		-4'sd3, -4'sd3, -4'sd4, -4'sd4, -4'sd4, -4'sd4, -4'sd4, -4'sd4, -4'sd4, -4'sd4,
		-4'sd4, -4'sd4, -4'sd3, -4'sd3, -4'sd2, -4'sd2, -4'sd1, -4'sd1, 4'sd0, 4'sd0
	};

	function automatic logic signed [3:0] wave_offset(input logic [RippleIdxW-1:0] k);
		logic [7:0] ke;
		ke = 8'(k);
		if (ke < 8'(WaveLen))
			wave_offset = WaveTable[ke[5:0]];
		else
			wave_offset = 4'sd0;
	endfunction

	// per-pixel data that rides alongside the fisheye units
	typedef struct packed {
		logic [3:0]         mode;
		logic [13:0]        px;
		logic [11:0]        py;
		logic [7:0]         r;
		logic [7:0]         g;
		logic [7:0]         b;
		logic signed [13:0] dx;
		logic signed [13:0] dy;
	} side_t;

	typedef struct packed {
		logic signed [13:0] dest_x;
		logic [11:0]        dest_y;
		logic [7:0]         red;
		logic [7:0]         green;
		logic [7:0]         blue;
	} res_t;

endpackage

// ----- hdl/pfx_pixel_if.sv -----
// pfx_pixel_if: source pixel channel, valid/ready with coordinate and color
// standalone, no package needed
interface pfx_pixel_if;
	logic        valid;
	logic        ready;
	logic [11:0] pixel_x;
	logic [11:0] pixel_y;
	logic [7:0]  in_red;
	logic [7:0]  in_green;
	logic [7:0]  in_blue;

	modport source(output valid, pixel_x, pixel_y, in_red, in_green, in_blue, input ready);
	modport sink(input valid, pixel_x, pixel_y, in_red, in_green, in_blue, output ready);
endinterface

// ----- hdl/pfx_result_if.sv -----
// pfx_result_if: result channel, valid/ready with destination and color
// standalone, no package needed
interface pfx_result_if;
	logic               valid;
	logic               ready;
	logic signed [13:0] dest_x;
	logic [11:0]        dest_y;
	logic [7:0]         out_red;
	logic [7:0]         out_green;
	logic [7:0]         out_blue;

	modport source(output valid, dest_x, dest_y, out_red, out_green, out_blue, input ready);
	modport sink(input valid, dest_x, dest_y, out_red, out_green, out_blue, output ready);
endinterface

// ----- hdl/pfx_sqrt_pipe.sv -----
// pfx_sqrt_pipe: integer square root, one result bit per register stage
// depends on pfx_pkg
module pfx_sqrt_pipe import pfx_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  logic [SqrtInW-1:0] rad,
	output logic [RootW-1:0]   root
);

	logic [SqrtInW-1:0] v_q    [SqrtSteps];
	logic [SqrtInW-1:0] root_q [SqrtSteps];

	for (genvar j = 0; j < SqrtSteps; j++) begin : g_step
		localparam logic [SqrtInW-1:0] Bit = SqrtInW'(1) << (2 * (SqrtSteps - 1 - j));
		logic [SqrtInW-1:0] v_in;
		logic [SqrtInW-1:0] r_in;
		logic [SqrtInW-1:0] trial;
		logic               ge;

		if (j == 0) begin : g_first
			assign v_in = rad;
			assign r_in = '0;
		end else begin : g_next
			assign v_in = v_q[j-1];
			assign r_in = root_q[j-1];
		end

		assign trial = r_in + Bit;
		assign ge = (v_in >= trial);

		always_ff @(posedge clk) begin
			if (en) begin
				v_q[j] <= ge ? v_in - trial : v_in;
				root_q[j] <= ge ? (r_in >> 1) + Bit : (r_in >> 1);
			end
		end
	end

	assign root = root_q[SqrtSteps-1][RootW-1:0];

endmodule

// ----- hdl/pfx_div_pipe.sv -----
// pfx_div_pipe: restoring divider, one quotient bit per register stage
// depends on pfx_pkg; quotient must fit in DivSteps bits
module pfx_div_pipe import pfx_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  logic [DivNumW-1:0] num,
	input  logic [RootW-1:0]   den,
	output logic [DivSteps-1:0] quot
);

	logic [RootW-1:0]    p_q    [DivSteps];
	logic [DivSteps-1:0] n_q    [DivSteps];
	logic [RootW-1:0]    den_q  [DivSteps];
	logic [DivSteps-1:0] quot_q [DivSteps];

	for (genvar j = 0; j < DivSteps; j++) begin : g_step
		logic [RootW-1:0]    p_in;
		logic [DivSteps-1:0] n_in;
		logic [RootW-1:0]    d_in;
		logic [DivSteps-1:0] q_in;
		logic [RootW:0]      t;
		logic                ge;
		logic [DivSteps-1:0] q_nx;

		if (j == 0) begin : g_first
			assign p_in = RootW'(num[DivNumW-1:DivSteps]);
			assign n_in = num[DivSteps-1:0];
			assign d_in = den;
			assign q_in = '0;
		end else begin : g_next
			assign p_in = p_q[j-1];
			assign n_in = n_q[j-1];
			assign d_in = den_q[j-1];
			assign q_in = quot_q[j-1];
		end

		assign t = {p_in, n_in[DivSteps-1-j]};
		assign ge = (t >= {1'b0, d_in});

		always_comb begin
			q_nx = q_in;
			q_nx[DivSteps-1-j] = ge;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				p_q[j] <= ge ? RootW'(t - {1'b0, d_in}) : t[RootW-1:0];
				n_q[j] <= n_in;
				den_q[j] <= d_in;
				quot_q[j] <= q_nx;
			end
		end
	end

	assign quot = quot_q[DivSteps-1];

endmodule

// ----- hdl/pixel_effect_unit.sv -----
// pixel_effect_unit: throughput one pixel per cycle while the skid is empty;
// the whole pipeline advances together, and a one-entry skid behind the output
// register takes the beat in flight when a result stalls
// arst_n clears all valid bits and loads effect_mode 0, frame 640 x 480
// depth is set by the fisheye path: 22 square-root stages and 25 divider stages
// depends on pfx_pkg, pfx_pixel_if, pfx_result_if, pfx_sqrt_pipe, pfx_div_pipe
module pixel_effect_unit import pfx_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	pfx_pixel_if.sink           pixel,
	pfx_result_if.source        result
);

	// configuration registers
	logic [3:0]  mode_q;
	logic [12:0] width_q;
	logic [12:0] height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= FX_NONE;
			width_q <= 13'd640;
			height_q <= 13'd480;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MODE:   mode_q <= cfg_data[3:0];
				CFG_WIDTH:  width_q <= cfg_data;
				CFG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// global advance: stop only when the skid holds a beat
	logic pipe_en;
	logic skid_vld_q;
	logic out_vld_q;

	assign pipe_en = !skid_vld_q;
	assign pixel.ready = pipe_en;

	// valid bits travel with the data
	logic               vld_s1, vld_s2, vld_s3;
	logic [SideLen-1:0] vld_side;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_side <= '0;
		end else if (pipe_en) begin
			vld_s1 <= pixel.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_side <= {vld_side[SideLen-2:0], vld_s3};
		end
	end

	// stage 1: capture the pixel beat
	logic [11:0] x_s1, y_s1;
	logic [7:0]  rgb_s1 [3];

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			x_s1 <= pixel.pixel_x & CoordMask;
			y_s1 <= pixel.pixel_y & CoordMask;
			rgb_s1[0] <= pixel.in_red;
			rgb_s1[1] <= pixel.in_green;
			rgb_s1[2] <= pixel.in_blue;
		end
	end

	// stage 2: center offsets, squares, sepia products, gray sum, ripple quotient
	logic signed [14:0]     dx_w, dy_w;
	logic signed [27:0]     dxsq_w, dysq_w;
	logic [RippleProdW-1:0] yprod_w;
	logic [17:0]            sprod_w [3][3];

	assign dx_w = $signed({2'b00, x_s1, 1'b0}) - $signed({2'b00, width_q});
	assign dy_w = $signed({2'b00, y_s1, 1'b0}) - $signed({2'b00, height_q});
	assign dxsq_w = $signed(dx_w[13:0]) * $signed(dx_w[13:0]);
	assign dysq_w = $signed(dy_w[13:0]) * $signed(dy_w[13:0]);
	assign yprod_w = RippleProdW'(y_s1) * RippleProdW'(RippleRecip);

	always_comb begin
		for (int c = 0; c < 3; c++)
			for (int i = 0; i < 3; i++)
				sprod_w[c][i] = 18'(SepiaCoef[c][i]) * 18'(rgb_s1[i]);
	end

	logic [11:0]        x_s2, y_s2, yd_s2;
	logic [7:0]         rgb_s2 [3];
	logic signed [13:0] dx_s2, dy_s2;
	logic [25:0]        dx2_s2, dy2_s2, w2_s2, h2_s2;
	logic [17:0]        sprod_s2 [3][3];
	logic [9:0]         gsum_s2;

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			x_s2 <= x_s1;
			y_s2 <= y_s1;
			rgb_s2 <= rgb_s1;
			dx_s2 <= dx_w[13:0];
			dy_s2 <= dy_w[13:0];
			dx2_s2 <= dxsq_w[25:0];
			dy2_s2 <= dysq_w[25:0];
			w2_s2 <= 26'(width_q) * 26'(width_q);
			h2_s2 <= 26'(height_q) * 26'(height_q);
			sprod_s2 <= sprod_w;
			gsum_s2 <= 10'(rgb_s1[0]) + 10'(rgb_s1[1]) + 10'(rgb_s1[2]);
			yd_s2 <= yprod_w[RippleShift +: 12];
		end
	end

	// stage 3: distance sums, sepia rounding and clamp, gray mean, ripple index
	logic [18:0] ssum_w [3];
	logic [7:0]  sep_w [3];
	logic [19:0] gprod_w;
	logic [11:0] kfull_w;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			ssum_w[c] = 19'(sprod_s2[c][0]) + 19'(sprod_s2[c][1]) + 19'(sprod_s2[c][2])
				+ 19'd512;
			sep_w[c] = (ssum_w[c][18:10] > 9'd255) ? 8'd255 : ssum_w[c][17:10];
		end
	end

	assign gprod_w = 20'(gsum_s2) * 20'(GrayRecip);
	assign kfull_w = y_s2 - 12'(yd_s2 * RipplePeriod);

	logic [11:0]           x_s3, y_s3;
	logic [7:0]            rgb_s3 [3];
	logic [7:0]            sep_s3 [3];
	logic [7:0]            gray_s3;
	logic [RippleIdxW-1:0] k_s3;
	logic signed [13:0]    dx_s3, dy_s3;
	logic [26:0]           sd_s3, sr_s3;

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			x_s3 <= x_s2;
			y_s3 <= y_s2;
			rgb_s3 <= rgb_s2;
			sep_s3 <= sep_w;
			gray_s3 <= gprod_w[18:11];
			k_s3 <= kfull_w[RippleIdxW-1:0];
			dx_s3 <= dx_s2;
			dy_s3 <= dy_s2;
			sd_s3 <= 27'(dx2_s2) + 27'(dy2_s2);
			sr_s3 <= 27'(w2_s2) + 27'(h2_s2);
		end
	end

	// point effects other than fisheye settle here, first entry of the side line
	side_t side_in;

	always_comb begin
		side_in.mode = mode_q;
		side_in.px = {2'b00, x_s3};
		side_in.py = y_s3;
		side_in.r = rgb_s3[0];
		side_in.g = rgb_s3[1];
		side_in.b = rgb_s3[2];
		side_in.dx = dx_s3;
		side_in.dy = dy_s3;
		unique case (mode_q)
			FX_NONE, FX_FISHEYE: ;
			FX_GRAY: begin
				side_in.r = gray_s3;
				side_in.g = gray_s3;
				side_in.b = gray_s3;
			end
			FX_INVERT: begin
				side_in.r = ~rgb_s3[0];
				side_in.g = ~rgb_s3[1];
				side_in.b = ~rgb_s3[2];
			end
			FX_MIRROR: side_in.py = 12'(height_q - 13'd1 - {1'b0, y_s3});
			FX_ZERO_R: side_in.r = 8'd0;
			FX_ZERO_G: side_in.g = 8'd0;
			FX_ZERO_B: side_in.b = 8'd0;
			FX_SEPIA: begin
				side_in.r = sep_s3[0];
				side_in.g = sep_s3[1];
				side_in.b = sep_s3[2];
			end
			FX_WAVE: side_in.px = 14'($signed({2'b00, x_s3}) + wave_offset(k_s3));
			default: begin
				side_in.r = 8'd0;
				side_in.g = 8'd0;
				side_in.b = 8'd0;
			end
		endcase
	end

	side_t side_q [SideLen];

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			side_q[0] <= side_in;
			for (int i = 1; i < SideLen; i++)
				side_q[i] <= side_q[i-1];
		end
	end

	// fisheye: doubled distances in Q8 through two root pipelines
	logic [RootW-1:0] d8, r8;

	pfx_sqrt_pipe u_sqrt_d (
		.clk  (clk),
		.en   (pipe_en),
		.rad  ({sd_s3, 16'd0}),
		.root (d8)
	);

	pfx_sqrt_pipe u_sqrt_r (
		.clk  (clk),
		.en   (pipe_en),
		.rad  ({sr_s3, 16'd0}),
		.root (r8)
	);

	// clamp the distance, then divide by the half-diagonal
	logic [M8W-1:0]      m8_q;
	logic [RootW-1:0]    r8_q;
	logic [DivSteps-1:0] quot;

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			m8_q <= (d8 < RootW'(M8Cap)) ? d8[M8W-1:0] : M8Cap;
			r8_q <= r8;
		end
	end

	pfx_div_pipe u_div (
		.clk  (clk),
		.en   (pipe_en),
		.num  ({m8_q, 16'd0}),
		.den  (r8_q),
		.quot (quot)
	);

	// scale factor one minus the ratio, in Q16; a zero frame has zero half-diagonal and scale factor 0
	logic signed [QW-1:0] q_q;
	logic signed [40:0]   mx_q, my_q;

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			if (width_q == 13'd0 && height_q == 13'd0)
				q_q <= '0;
			else
				q_q <= QW'(65536) - $signed({2'b00, quot});
			mx_q <= side_q[SideLen-2].dx * q_q;
			my_q <= side_q[SideLen-2].dy * q_q;
		end
	end

	// final: half of the doubled coordinate, rounded half up, floor by arithmetic shift
	logic signed [41:0] fx_sum, fy_sum, fx_sh, fy_sh;
	res_t fin;

	assign fx_sum = $signed({13'd0, width_q, 16'd0}) + 42'(mx_q) + 42'sd65536;
	assign fy_sum = $signed({13'd0, height_q, 16'd0}) + 42'(my_q) + 42'sd65536;
	assign fx_sh = fx_sum >>> 17;
	assign fy_sh = fy_sum >>> 17;

	always_comb begin
		fin.dest_x = side_q[SideLen-1].px;
		fin.dest_y = side_q[SideLen-1].py;
		fin.red = side_q[SideLen-1].r;
		fin.green = side_q[SideLen-1].g;
		fin.blue = side_q[SideLen-1].b;
		if (side_q[SideLen-1].mode == FX_FISHEYE) begin
			fin.dest_x = fx_sh[13:0];
			fin.dest_y = fy_sh[11:0];
		end
	end

	// output register with a one-beat skid
	res_t out_q, skid_q;
	logic incoming;

	assign incoming = vld_side[SideLen-1] && pipe_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || result.ready) begin
			if (skid_vld_q) begin
				out_vld_q <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= incoming;
			end
		end else if (incoming) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || result.ready) begin
			if (skid_vld_q)
				out_q <= skid_q;
			else if (incoming)
				out_q <= fin;
		end else if (incoming) begin
			skid_q <= fin;
		end
	end

	assign result.valid = out_vld_q;
	assign result.dest_x = out_q.dest_x;
	assign result.dest_y = out_q.dest_y;
	assign result.out_red = out_q.red;
	assign result.out_green = out_q.green;
	assign result.out_blue = out_q.blue;

`ifndef SYNTHESIS
	// a beat in the skid always has one ahead of it in the output register
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid holds a beat while output register is empty");

	// a stalled output with a beat arriving must park it in the skid
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !result.ready && incoming) |=> skid_vld_q)
		else $error("arriving beat not parked in skid");

	// while the pipeline is held, the last stage keeps its valid bit
	a_hold_last: assert property (@(posedge clk) disable iff (!arst_n)
		!pipe_en |=> $stable(vld_side[SideLen-1]))
		else $error("last stage changed during stall");

	// a full skid drains into the output register once the beat ahead is taken
	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_vld_q && result.ready) |=> (out_vld_q && !skid_vld_q))
		else $error("skid did not drain");
`endif

endmodule
